// ===== design/pendulum_plant_euler_step_top_assert.svh =====
// Assertion shorthands for the pendulum plant block.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef PENDULUM_PLANT_EULER_STEP_TOP_ASSERT_SVH
`define PENDULUM_PLANT_EULER_STEP_TOP_ASSERT_SVH

// cond at this edge implies prop at the same edge
`define PPES_ASSERT_SAME(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("pendulum plant check failed");

// cond at this edge implies prop at the next edge
`define PPES_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("pendulum plant check failed");

`endif

// ===== design/ppes_pkg.sv =====
package ppes_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_STEP_SIZE       = 3'd0;
    localparam logic [2:0] CFG_COEF_VEL_VEL    = 3'd1;
    localparam logic [2:0] CFG_COEF_VEL_ANGLE  = 3'd2;
    localparam logic [2:0] CFG_COEF_RATE_VEL   = 3'd3;
    localparam logic [2:0] CFG_COEF_RATE_ANGLE = 3'd4;
    localparam logic [2:0] CFG_GAIN_VEL_FORCE  = 3'd5;
    localparam logic [2:0] CFG_GAIN_RATE_FORCE = 3'd6;

    localparam logic [23:0] STEP_SIZE_RESET = 24'd16777;

    // op codes
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // multiplier schedule, one product per code
    localparam logic [3:0] MS_VEL_BY_VEL    = 4'd0;
    localparam logic [3:0] MS_VEL_BY_ANGLE  = 4'd1;
    localparam logic [3:0] MS_VEL_BY_FORCE  = 4'd2;
    localparam logic [3:0] MS_RATE_BY_VEL   = 4'd3;
    localparam logic [3:0] MS_RATE_BY_ANGLE = 4'd4;
    localparam logic [3:0] MS_RATE_BY_FORCE = 4'd5;
    localparam logic [3:0] MS_POS_INC       = 4'd6;
    localparam logic [3:0] MS_ANGLE_INC     = 4'd7;
    localparam logic [3:0] MS_VEL_INC_LO    = 4'd8;
    localparam logic [3:0] MS_VEL_INC_HI    = 4'd9;
    localparam logic [3:0] MS_RATE_INC_LO   = 4'd10;
    localparam logic [3:0] MS_RATE_INC_HI   = 4'd11;
    localparam logic [3:0] NUM_MUL_STEPS    = 4'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROUND,
        ST_WRITE
    } ctl_state_t;

    typedef struct packed {
        logic       start;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       round_en;
        logic       write_en;
    } ctl_cmd_t;

endpackage

// ===== design/ppes_ctrl.sv =====
module ppes_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                in_op,
    output logic                s_tready,
    input  logic                m_tready,
    output logic                m_tvalid,
    output ppes_pkg::ctl_cmd_t  cmd
);

    ppes_pkg::ctl_state_t state_reg, state_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ppes_pkg::ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = cnt_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            ppes_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = (in_op == ppes_pkg::OP_LOAD) ? ppes_pkg::ST_WRITE
                                                              : ppes_pkg::ST_MUL;
                end
            end
            ppes_pkg::ST_MUL: begin
                // last count only drains the product register
                cmd.mul_en = (cnt_reg != ppes_pkg::NUM_MUL_STEPS);
                if (cnt_reg == ppes_pkg::NUM_MUL_STEPS) begin
                    state_next = ppes_pkg::ST_ROUND;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ppes_pkg::ST_ROUND: begin
                cmd.round_en = 1'b1;
                state_next   = ppes_pkg::ST_WRITE;
            end
            ppes_pkg::ST_WRITE: begin
                // hold until the output slot is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.write_en = 1'b1;
                    state_next   = ppes_pkg::ST_IDLE;
                end
            end
            default: state_next = ppes_pkg::ST_IDLE;
        endcase
        m_tvalid_next = cmd.write_en | (m_tvalid_reg & ~m_tready);
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== design/ppes_dpath.sv =====
module ppes_dpath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_op,
    input  logic [31:0]        in_force,
    input  logic [31:0]        in_init_pos,
    input  logic [31:0]        in_init_angle,
    input  ppes_pkg::ctl_cmd_t cmd,
    output logic [31:0]        out_position,
    output logic [31:0]        out_velocity,
    output logic [31:0]        out_angle,
    output logic [31:0]        out_rate,
    output logic               out_saturated
);

    // round step*d (40 fraction bits) to Q16.16, ties away from zero
    function automatic logic signed [41:0] round_q(input logic signed [65:0] p);
        logic [65:0] biased;
        biased = p + 66'h7FFFFF + {65'd0, ~p[65]};
        return $signed(biased[65:24]);
    endfunction

    // old + inc clipped to 32 bits, clip flag in the top bit
    function automatic logic [32:0] sat_add(input logic signed [31:0] old,
                                            input logic signed [41:0] inc);
        logic signed [42:0] s;
        s = {{11{old[31]}}, old} + {inc[41], inc};
        if (s[42:31] == '0 || s[42:31] == '1) begin
            return {1'b0, s[31:0]};
        end
        return {1'b1, s[42] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    endfunction

    logic [23:0]        step_size_reg;
    logic signed [31:0] cvv_reg, cva_reg, crv_reg, cra_reg, gvf_reg, grf_reg;

    logic signed [31:0] position_reg, velocity_reg, angle_reg, rate_reg;
    logic               op_reg;
    logic signed [31:0] force_reg, init_pos_reg, init_angle_reg;

    logic signed [32:0] mul_a, mul_b, step_ext;
    logic signed [65:0] mul_p_reg;
    logic [3:0]         tag_reg;
    logic               tag_vld_reg;

    logic signed [57:0] acc_v_reg, acc_w_reg;
    logic signed [65:0] prod_x_reg, prod_v_reg, prod_a_reg, prod_w_reg;
    logic signed [41:0] dv, dw;
    logic signed [41:0] inc_x_reg, inc_v_reg, inc_a_reg, inc_w_reg;

    logic [32:0] sx, sv, sa, sw;

    logic [31:0] out_position_reg, out_velocity_reg, out_angle_reg, out_rate_reg;
    logic        out_saturated_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= ppes_pkg::STEP_SIZE_RESET;
            cvv_reg       <= '0;
            cva_reg       <= '0;
            crv_reg       <= '0;
            cra_reg       <= '0;
            gvf_reg       <= '0;
            grf_reg       <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ppes_pkg::CFG_STEP_SIZE:       step_size_reg <= cfg_wdata[23:0];
                ppes_pkg::CFG_COEF_VEL_VEL:    cvv_reg <= cfg_wdata;
                ppes_pkg::CFG_COEF_VEL_ANGLE:  cva_reg <= cfg_wdata;
                ppes_pkg::CFG_COEF_RATE_VEL:   crv_reg <= cfg_wdata;
                ppes_pkg::CFG_COEF_RATE_ANGLE: cra_reg <= cfg_wdata;
                ppes_pkg::CFG_GAIN_VEL_FORCE:  gvf_reg <= cfg_wdata;
                ppes_pkg::CFG_GAIN_RATE_FORCE: grf_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg         <= in_op;
            force_reg      <= in_force;
            init_pos_reg   <= in_init_pos;
            init_angle_reg <= in_init_angle;
        end
    end

    // derivatives: floor of the Q26.32 sum by 16
    assign dv       = acc_v_reg[57:16];
    assign dw       = acc_w_reg[57:16];
    assign step_ext = $signed({9'd0, step_size_reg});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            ppes_pkg::MS_VEL_BY_VEL: begin
                mul_a = {velocity_reg[31], velocity_reg};
                mul_b = {cvv_reg[31], cvv_reg};
            end
            ppes_pkg::MS_VEL_BY_ANGLE: begin
                mul_a = {angle_reg[31], angle_reg};
                mul_b = {cva_reg[31], cva_reg};
            end
            ppes_pkg::MS_VEL_BY_FORCE: begin
                mul_a = {force_reg[31], force_reg};
                mul_b = {gvf_reg[31], gvf_reg};
            end
            ppes_pkg::MS_RATE_BY_VEL: begin
                mul_a = {velocity_reg[31], velocity_reg};
                mul_b = {crv_reg[31], crv_reg};
            end
            ppes_pkg::MS_RATE_BY_ANGLE: begin
                mul_a = {angle_reg[31], angle_reg};
                mul_b = {cra_reg[31], cra_reg};
            end
            ppes_pkg::MS_RATE_BY_FORCE: begin
                mul_a = {force_reg[31], force_reg};
                mul_b = {grf_reg[31], grf_reg};
            end
            ppes_pkg::MS_POS_INC: begin
                mul_a = {velocity_reg[31], velocity_reg};
                mul_b = step_ext;
            end
            ppes_pkg::MS_ANGLE_INC: begin
                mul_a = {rate_reg[31], rate_reg};
                mul_b = step_ext;
            end
            ppes_pkg::MS_VEL_INC_LO: begin
                mul_a = $signed({1'b0, dv[31:0]});
                mul_b = step_ext;
            end
            ppes_pkg::MS_VEL_INC_HI: begin
                mul_a = {{23{dv[41]}}, dv[41:32]};
                mul_b = step_ext;
            end
            ppes_pkg::MS_RATE_INC_LO: begin
                mul_a = $signed({1'b0, dw[31:0]});
                mul_b = step_ext;
            end
            ppes_pkg::MS_RATE_INC_HI: begin
                mul_a = {{23{dw[41]}}, dw[41:32]};
                mul_b = step_ext;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
        tag_reg   <= cmd.mul_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_vld_reg <= 1'b0;
        end else begin
            tag_vld_reg <= cmd.mul_en;
        end
    end

    // fold each product into its sum, or store it, in the cycle after the multiply
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_v_reg  <= '0;
            acc_w_reg  <= '0;
            prod_x_reg <= '0;
            prod_v_reg <= '0;
            prod_a_reg <= '0;
            prod_w_reg <= '0;
        end else if (tag_vld_reg) begin
            case (tag_reg) inside
                ppes_pkg::MS_VEL_BY_VEL, ppes_pkg::MS_VEL_BY_ANGLE,
                ppes_pkg::MS_VEL_BY_FORCE:
                    acc_v_reg <= acc_v_reg + mul_p_reg[65:8];
                ppes_pkg::MS_RATE_BY_VEL, ppes_pkg::MS_RATE_BY_ANGLE,
                ppes_pkg::MS_RATE_BY_FORCE:
                    acc_w_reg <= acc_w_reg + mul_p_reg[65:8];
                ppes_pkg::MS_POS_INC:     prod_x_reg <= mul_p_reg;
                ppes_pkg::MS_ANGLE_INC:   prod_a_reg <= mul_p_reg;
                ppes_pkg::MS_VEL_INC_LO:  prod_v_reg <= prod_v_reg + mul_p_reg;
                ppes_pkg::MS_VEL_INC_HI:
                    prod_v_reg <= prod_v_reg + {mul_p_reg[33:0], 32'd0};
                ppes_pkg::MS_RATE_INC_LO: prod_w_reg <= prod_w_reg + mul_p_reg;
                ppes_pkg::MS_RATE_INC_HI:
                    prod_w_reg <= prod_w_reg + {mul_p_reg[33:0], 32'd0};
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round_en) begin
            inc_x_reg <= round_q(prod_x_reg);
            inc_v_reg <= round_q(prod_v_reg);
            inc_a_reg <= round_q(prod_a_reg);
            inc_w_reg <= round_q(prod_w_reg);
        end
    end

    always_comb begin
        sx = sat_add(position_reg, inc_x_reg);
        sv = sat_add(velocity_reg, inc_v_reg);
        sa = sat_add(angle_reg, inc_a_reg);
        sw = sat_add(rate_reg, inc_w_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            velocity_reg <= '0;
            angle_reg    <= '0;
            rate_reg     <= '0;
        end else if (cmd.write_en) begin
            if (op_reg == ppes_pkg::OP_LOAD) begin
                position_reg <= init_pos_reg;
                velocity_reg <= '0;
                angle_reg    <= init_angle_reg;
                rate_reg     <= '0;
            end else begin
                position_reg <= sx[31:0];
                velocity_reg <= sv[31:0];
                angle_reg    <= sa[31:0];
                rate_reg     <= sw[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_en) begin
            if (op_reg == ppes_pkg::OP_LOAD) begin
                out_position_reg  <= init_pos_reg;
                out_velocity_reg  <= '0;
                out_angle_reg     <= init_angle_reg;
                out_rate_reg      <= '0;
                out_saturated_reg <= 1'b0;
            end else begin
                out_position_reg  <= sx[31:0];
                out_velocity_reg  <= sv[31:0];
                out_angle_reg     <= sa[31:0];
                out_rate_reg      <= sw[31:0];
                out_saturated_reg <= sx[32] | sv[32] | sa[32] | sw[32];
            end
        end
    end

    assign out_position  = out_position_reg;
    assign out_velocity  = out_velocity_reg;
    assign out_angle     = out_angle_reg;
    assign out_rate      = out_rate_reg;
    assign out_saturated = out_saturated_reg;

endmodule

// ===== design/pendulum_plant_euler_step_top.sv =====
// Linearized cart-pole plant, one forward Euler step per advance word.
// Input channel (s_): s_tuser carries op (0 advance, 1 load); s_tdata carries
//   force_req, init_position and init_angle, all signed Q16.16.
// Result channel (m_): one word per input word with the new state and a
//   flag that marks a clipped component.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 step
//   size, 1..4 coefficients, 5..6 force gains); write only while no word is
//   in flight.
// Sequence: an advance word passes through the MUL, ROUND and WRITE states;
//   a load word goes straight to WRITE. The input takes no new word until
//   the sequencer is back in IDLE. In MUL the single 33x33 multiplier forms
//   twelve products in turn and a final drain count folds the last one;
//   ROUND rounds the increments and WRITE updates the state and the result
//   register.
// Stall: a finished result waits in the output register; the next word is
//   taken and computed meanwhile and its update holds until that result
//   leaves, so nothing is lost or overwritten.
// Reset (aresetn low, synchronous): state zero, step size 16777, all
//   coefficients zero, both channels empty.
`include "pendulum_plant_euler_step_top_assert.svh"

module pendulum_plant_euler_step_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // force_req, init_position, init_angle
    input  logic [0:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // cart_position, cart_velocity, pend_angle,
                                    // pend_rate, saturated, zero fill
);

    ppes_pkg::ctl_cmd_t cmd;
    logic [31:0]        cart_position, cart_velocity, pend_angle, pend_rate;
    logic               saturated;

    // sequencer: accept, multiply schedule, round, update
    ppes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tuser[0]),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // config registers, plant state, shared multiplier and result register
    ppes_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_op         (s_tuser[0]),
        .in_force      (s_tdata[31:0]),
        .in_init_pos   (s_tdata[63:32]),
        .in_init_angle (s_tdata[95:64]),
        .cmd           (cmd),
        .out_position  (cart_position),
        .out_velocity  (cart_velocity),
        .out_angle     (pend_angle),
        .out_rate      (pend_rate),
        .out_saturated (saturated)
    );

    assign m_tdata = {7'd0, saturated, pend_rate, pend_angle, cart_velocity, cart_position};

    // one word at a time: the input closes right after it takes a word
    `PPES_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // an update never lands on a result that has not left yet
    `PPES_ASSERT_SAME(a_no_overwrite, cmd.write_en, !m_tvalid || m_tready)
    // an advance word starts the multiply schedule at its first product
    `PPES_ASSERT_NEXT(a_advance_starts, s_tvalid && s_tready && !s_tuser[0],
                      cmd.mul_en && cmd.mul_sel == ppes_pkg::MS_VEL_BY_VEL)

endmodule
